FILE: src/assert_macros.svh
// Assertion macros shared by the RTL files.
// Under SYNTHESIS each macro expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, disabled while reset is asserted
`define CTT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define CTT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CTT_ASSERT(lbl, clk, rst_n, prop, msg)
`define CTT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: src/ctt_pkg.sv
// ----------------------------------------------------------------------------
// ctt_pkg
// Types, codes and sizes shared by the completion tree tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ctt_pkg;

  // Table sizes
  localparam int MAX_NODES = 64;
  localparam int ID_WIDTH  = 32;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int STEP_W    = $clog2(MAX_NODES + 1);

  // Fixed field widths
  localparam int CNT_W  = 7;
  localparam int LINK_W = 7;
  localparam int EIDX_W = 6;

  // Entry kinds
  localparam logic [1:0] KIND_LEAF = 2'd0;
  localparam logic [1:0] KIND_ALL  = 2'd1;
  localparam logic [1:0] KIND_ANY  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_LOADED   = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_ALREADY  = 2'd2;
  localparam logic [1:0] ST_PROP     = 2'd3;

  // Item modes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_NOTIFY = 1'b1;

  // Input beat
  typedef struct packed {
    logic                mode;
    logic [EIDX_W-1:0]   entry_index;
    logic [1:0]          entry_kind;
    logic [CNT_W-1:0]    entry_needs;
    logic [LINK_W-1:0]   entry_parent;
    logic [ID_WIDTH-1:0] task_id;
  } in_t;

  // Result beat
  typedef struct packed {
    logic [1:0] status;
    logic       root_done;
    logic       notify_result;
  } out_t;

  // One stored tree entry
  typedef struct packed {
    logic [1:0]          kind;
    logic [ID_WIDTH-1:0] id;
    logic [LINK_W-1:0]   parent;
    logic [CNT_W-1:0]    needs;
    logic [CNT_W-1:0]    done;
  } entry_t;

  // Handshake between the top level and the engine
  typedef struct packed {
    logic start;
    logic res_ack;
  } eng_ctl_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } eng_sts_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_WALK_RD,
    S_WALK_UPD,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

FILE: src/ctt_engine.sv
// ----------------------------------------------------------------------------
// ctt_engine
// Entry table and sequencer: loads entries, searches for a task leaf and
// walks the parent chain one entry at a time through a simple dual-port table.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ctt_engine (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire ctt_pkg::eng_ctl_t            ctl,
  input  wire ctt_pkg::in_t                 item,
  input  wire logic [ctt_pkg::CNT_W-1:0]    node_count,
  output ctt_pkg::eng_sts_t                 sts,
  output ctt_pkg::out_t                     res
);
  import ctt_pkg::*;

  // Entry table, one write and one registered read per cycle
  entry_t mem [MAX_NODES];
  entry_t rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             we;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     pos_r, pos_nxt;
  logic [LINK_W-1:0]    at_r, at_nxt;
  logic [STEP_W-1:0]    steps_r, steps_nxt;
  logic [ID_WIDTH-1:0]  tid_r, tid_nxt;
  logic [1:0]           status_r, status_nxt;
  logic [MAX_NODES-1:0] flags_r, flags_nxt;

  logic [CNT_W-1:0] count_clamp;
  logic [CNT_W-1:0] done_inc;
  logic             fin_new;
  logic [IDX_W-1:0] at_idx;

  assign at_idx      = at_r[IDX_W-1:0];
  assign count_clamp = (node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count;
  assign done_inc    = rd_data_r.done + CNT_W'(1);

  // Finish rule for the entry just read on the walk
  always_comb begin
    case (rd_data_r.kind)
      KIND_ALL: fin_new = flags_r[at_idx] | (done_inc == rd_data_r.needs);
      KIND_ANY: fin_new = 1'b1;
      default:  fin_new = flags_r[at_idx];
    endcase
  end

  // Table write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      flags_r  <= '0;
      steps_r  <= '0;
      status_r <= ST_LOADED;
    end else begin
      state_r  <= state_nxt;
      flags_r  <= flags_nxt;
      steps_r  <= steps_nxt;
      status_r <= status_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    at_r  <= at_nxt;
    tid_r <= tid_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    at_nxt     = at_r;
    steps_nxt  = steps_r;
    tid_nxt    = tid_r;
    status_nxt = status_r;
    flags_nxt  = flags_r;
    rd_addr    = pos_r;
    we         = 1'b0;
    wr_addr    = at_idx;
    wr_data    = rd_data_r;
    case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          tid_nxt = item.task_id;
          if (item.mode == MODE_LOAD) begin
            // Write the entry and clear its counts
            if (LINK_W'(item.entry_index) < LINK_W'(MAX_NODES)) begin
              we             = 1'b1;
              wr_addr        = item.entry_index[IDX_W-1:0];
              wr_data.kind   = item.entry_kind;
              wr_data.id     = item.task_id;
              wr_data.parent = item.entry_parent;
              wr_data.needs  = item.entry_needs;
              wr_data.done   = '0;
              flags_nxt[item.entry_index[IDX_W-1:0]] = 1'b0;
            end
            status_nxt = ST_LOADED;
            state_nxt  = S_RESP;
          end else if (count_clamp == '0) begin
            status_nxt = ST_NOTFOUND;
            state_nxt  = S_RESP;
          end else begin
            pos_nxt   = IDX_W'(count_clamp - CNT_W'(1));
            state_nxt = S_SRCH_RD;
          end
        end
      end
      S_SRCH_RD: begin
        rd_addr   = pos_r;
        state_nxt = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        // Compare one entry, highest index first
        if (rd_data_r.kind == KIND_LEAF && rd_data_r.id == tid_r) begin
          if (flags_r[pos_r]) begin
            status_nxt = ST_ALREADY;
            state_nxt  = S_RESP;
          end else begin
            flags_nxt[pos_r] = 1'b1;
            at_nxt           = rd_data_r.parent;
            steps_nxt        = '0;
            status_nxt       = ST_PROP;
            state_nxt        = S_WALK_RD;
          end
        end else if (pos_r == '0) begin
          status_nxt = ST_NOTFOUND;
          state_nxt  = S_RESP;
        end else begin
          pos_nxt   = pos_r - IDX_W'(1);
          state_nxt = S_SRCH_RD;
        end
      end
      S_WALK_RD: begin
        // Stop above the root or after a full table of steps
        rd_addr = at_idx;
        if (at_r >= LINK_W'(MAX_NODES) || steps_r == STEP_W'(MAX_NODES)) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_WALK_UPD;
        end
      end
      S_WALK_UPD: begin
        // Count this child and decide whether the gate finished
        we                = 1'b1;
        wr_addr           = at_idx;
        wr_data.done      = done_inc;
        flags_nxt[at_idx] = fin_new;
        if (fin_new) begin
          at_nxt    = rd_data_r.parent;
          steps_nxt = steps_r + STEP_W'(1);
          state_nxt = S_WALK_RD;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (ctl.res_ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Status toward the top level
  assign sts.idle          = (state_r == S_IDLE);
  assign sts.res_valid     = (state_r == S_RESP);
  assign res.status        = status_r;
  assign res.root_done     = flags_r[0];
  assign res.notify_result = (status_r == ST_PROP) && flags_r[0];

  // Checks
  `CTT_ASSERT(a_start_idle, clk, rst_n, ctl.start |-> state_r == S_IDLE, "start while busy")
  `CTT_ASSERT(a_load_resp, clk, rst_n,
              (ctl.start && item.mode == MODE_LOAD) |=> state_r == S_RESP,
              "load did not finish in one cycle")
  `CTT_ASSERT(a_steps_bound, clk, rst_n, steps_r <= STEP_W'(MAX_NODES),
              "walk step count overran")
  `CTT_ASSERT(a_walk_prop, clk, rst_n,
              (state_r == S_WALK_RD || state_r == S_WALK_UPD) |-> status_r == ST_PROP,
              "walk without propagated status")

endmodule

`default_nettype wire

FILE: src/completion_tree_tracker_top.sv
// ----------------------------------------------------------------------------
// completion_tree_tracker_top
// Completion tree tracker: entry loads and task-finished notifies in,
// one status beat out per item.
// ----------------------------------------------------------------------------
// Items are taken one at a time; in_stall stays high until the current item's
// result has moved into the output register. A load writes its entry and then
// gives its result. A notify reads and checks each entry searched (from
// node_count-1 down to the matching leaf or entry 0); for a leaf not yet done it
// then reads and updates each entry visited on the parent walk, until a gate
// does not finish, the walk runs off the top of the tree or it hits the step
// limit. The entry table has one write port and one registered read port, which
// serve both the search and the walk. A result waiting in the output register
// does not hold back the next item. The node_count register resets to 1 and
// may be written whenever the block is idle.
`default_nettype none

module completion_tree_tracker_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // Input channel
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire ctt_pkg::in_t              in_data,
  // Result channel
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output ctt_pkg::out_t                  out_data,
  // Configuration write channel
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [ctt_pkg::CNT_W-1:0] cfg_data
);
  import ctt_pkg::*;

  logic [CNT_W-1:0] node_count_r;
  logic             out_valid_r;
  out_t             out_data_r;
  eng_ctl_t         ctl;
  eng_sts_t         sts;
  out_t             res;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= CNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      node_count_r <= cfg_data;
    end
  end

  // Engine handshake
  assign in_stall    = !sts.idle;
  assign ctl.start   = in_valid && !in_stall;
  assign ctl.res_ack = sts.res_valid && (!out_valid_r || !out_stall);

  ctt_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .item       (in_data),
    .node_count (node_count_r),
    .sts        (sts),
    .res        (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.res_ack) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_ack) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
